FILE: hw/rtl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// types and codes shared by the template slot directory modules
// ----------------------------------------------------------------------------
package tsd_pkg;

  // slot state codes (code 3 is never written and reads as empty)
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_ACTIVE  = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  // command codes
  localparam logic [1:0] OP_SAVE    = 2'd0;
  localparam logic [1:0] OP_DEL_ID  = 2'd1;
  localparam logic [1:0] OP_DEL_ALL = 2'd2;
  localparam logic [1:0] OP_LIST    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT = 2'd1;
  localparam logic [1:0] STAT_BAD_LEN = 2'd2;

  // most results one list command reports
  localparam int MAX_LIST = 16;
  localparam int CNT_W    = $clog2(MAX_LIST + 1);

  // one directory slot
  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] key;
    logic [7:0]  kind;
    logic [12:0] nbytes;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } fsm_t;

endpackage

FILE: hw/rtl/template_slot_directory.sv
// ----------------------------------------------------------------------------
// template_slot_directory
// directory of fixed template slots (empty, active or tombstoned) kept in a
// ring of slot cells that rotates past a command sequencer
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   opcode, template key/kind/bytes
//   out_      output     out_valid / out_stall status, slot index, found,
//                                              entry key/kind/bytes, last
//
// each transaction rotates the ring once between being accepted and posting
// its final result; a save that finds a slot rotates a second time to write
// it, and a save with a bad length skips the ring entirely
// reset (synchronous, rst_n low) marks every slot empty and the directory
// unformatted at once; no clearing pass is needed
// a stalled output holds the list scan at the next reported slot; one more
// result waits in the output register while the next transaction is taken
//
module template_slot_directory import tsd_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int SLOT_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_template_key,
  input  logic [7:0]  in_template_kind,
  input  logic [12:0] in_template_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic        out_found,
  output logic [15:0] out_entry_key,
  output logic [7:0]  out_entry_kind,
  output logic [12:0] out_entry_bytes,
  output logic        out_last
);

  // ring of slots: cell 0 is the head seen by the sequencer, the slot it
  // writes back enters at the tail, so a full rotation restores the order
  slot_t cell_q [NUM_SLOTS];
  slot_t cell_d [NUM_SLOTS];
  slot_t wb;
  logic  shift_en;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign cell_d[i] = wb;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i + 1];
    end

    tsd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (cell_d[i]),
      .q        (cell_q[i])
    );
  end

  // sequencer: slot search, tombstoning, list and the result register
  tsd_ctrl #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_template_key   (in_template_key),
    .in_template_kind  (in_template_kind),
    .in_template_bytes (in_template_bytes),
    .head              (cell_q[0]),
    .shift_en          (shift_en),
    .wb                (wb),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_found         (out_found),
    .out_entry_key     (out_entry_key),
    .out_entry_kind    (out_entry_kind),
    .out_entry_bytes   (out_entry_bytes),
    .out_last          (out_last)
  );

endmodule

FILE: hw/rtl/tsd_cell.sv
// ----------------------------------------------------------------------------
// tsd_cell
// one slot of the directory ring, takes its input slot on each shift (its neighbor's, or the write-back at the tail)
// ----------------------------------------------------------------------------
module tsd_cell import tsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  slot_t d_in,
  output slot_t q
);

  logic [1:0]  st_r;
  logic [15:0] key_r;
  logic [7:0]  kind_r;
  logic [12:0] nbytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SLOT_EMPTY;
    end else if (shift_en) begin
      st_r <= d_in.st;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r    <= d_in.key;
      kind_r   <= d_in.kind;
      nbytes_r <= d_in.nbytes;
    end
  end

  assign q = '{st: st_r, key: key_r, kind: kind_r, nbytes: nbytes_r};

endmodule

FILE: hw/rtl/tsd_ctrl.sv
// ----------------------------------------------------------------------------
// tsd_ctrl
// command sequencer at the head of the slot ring, with result register
// ----------------------------------------------------------------------------
module tsd_ctrl import tsd_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int SLOT_BYTES = 4096,
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_template_key,
  input  logic [7:0]  in_template_kind,
  input  logic [12:0] in_template_bytes,
  input  slot_t       head,
  output logic        shift_en,
  output slot_t       wb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic        out_found,
  output logic [15:0] out_entry_key,
  output logic [7:0]  out_entry_kind,
  output logic [12:0] out_entry_bytes,
  output logic        out_last
);

  function automatic logic [3:0] idx4(input logic [IDX_W-1:0] v);
    logic [IDX_W+3:0] e;
    e = {4'b0, v};
    return e[3:0];
  endfunction

  fsm_t             state_r, state_nxt;
  logic             formatted_r, formatted_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [15:0]      key_r, key_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [12:0]      bytes_r, bytes_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             emp_v_r, emp_v_nxt;
  logic [IDX_W-1:0] emp_idx_r, emp_idx_nxt;
  logic             del_v_r, del_v_nxt;
  logic [IDX_W-1:0] del_idx_r, del_idx_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  slot_t            pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [3:0]       out_idx_r, out_idx_nxt;
  logic             out_found_r, out_found_nxt;
  logic [15:0]      out_key_r, out_key_nxt;
  logic [7:0]       out_kind_r, out_kind_nxt;
  logic [12:0]      out_bytes_r, out_bytes_nxt;
  logic             out_last_r, out_last_nxt;

  logic out_load, out_free, last_pos, head_used, key_eq, list_ok, bad_len, blocked;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_pos  = (pos_r == IDX_W'(NUM_SLOTS - 1));
  assign head_used = (head.st == SLOT_ACTIVE) || (head.st == SLOT_DELETED);
  assign key_eq    = (head.key == key_r);
  assign list_ok   = formatted_r && (head.st == SLOT_ACTIVE) && (head.nbytes != 13'd0) &&
                     (32'(head.nbytes) <= 32'(SLOT_BYTES)) && (cnt_r < CNT_W'(MAX_LIST));
  assign bad_len   = (in_template_bytes == 13'd0) ||
                     (32'(in_template_bytes) > 32'(SLOT_BYTES));
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    formatted_nxt  = formatted_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    kind_nxt       = kind_r;
    bytes_nxt      = bytes_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    emp_v_nxt      = emp_v_r;
    emp_idx_nxt    = emp_idx_r;
    del_v_nxt      = del_v_r;
    del_idx_nxt    = del_idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    cnt_nxt        = cnt_r;
    shift_en       = 1'b0;
    wb             = head;
    blocked        = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_found_nxt  = out_found_r;
    out_key_nxt    = out_key_r;
    out_kind_nxt   = out_kind_r;
    out_bytes_nxt  = out_bytes_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          key_nxt        = in_template_key;
          kind_nxt       = in_template_kind;
          bytes_nxt      = in_template_bytes;
          pos_nxt        = '0;
          hit_nxt        = 1'b0;
          emp_v_nxt      = 1'b0;
          del_v_nxt      = 1'b0;
          res_status_nxt = STAT_OK;
          res_found_nxt  = 1'b0;
          res_idx_nxt    = '0;
          pend_v_nxt     = 1'b0;
          cnt_nxt        = '0;
          if (in_opcode == OP_SAVE && bad_len) begin
            res_status_nxt = STAT_BAD_LEN;
            state_nxt      = ST_RESP;
          end else begin
            if (in_opcode == OP_SAVE) begin
              formatted_nxt = 1'b1;
            end
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        case (op_r)
          OP_SAVE: begin
            if (!hit_r) begin
              if (head_used && key_eq) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = pos_r;
              end else if (!head_used && !emp_v_r) begin
                emp_v_nxt   = 1'b1;
                emp_idx_nxt = pos_r;
              end else if (head.st == SLOT_DELETED && !del_v_r) begin
                del_v_nxt   = 1'b1;
                del_idx_nxt = pos_r;
              end
            end
          end
          OP_DEL_ID: begin
            if (formatted_r && !res_found_r && head.st == SLOT_ACTIVE && key_eq) begin
              wb.st         = SLOT_DELETED;
              res_found_nxt = 1'b1;
              res_idx_nxt   = pos_r;
            end
          end
          OP_DEL_ALL: begin
            if (formatted_r && head.st == SLOT_ACTIVE) begin
              wb.st         = SLOT_DELETED;
              res_found_nxt = 1'b1;
            end
          end
          default: begin
            if (list_ok) begin
              if (pend_v_r && !out_free) begin
                blocked = 1'b1;
              end else begin
                if (pend_v_r) begin
                  // previous entry is not the final one
                  out_load       = 1'b1;
                  out_status_nxt = STAT_OK;
                  out_idx_nxt    = idx4(pend_idx_r);
                  out_found_nxt  = 1'b1;
                  out_key_nxt    = pend_r.key;
                  out_kind_nxt   = pend_r.kind;
                  out_bytes_nxt  = pend_r.nbytes;
                  out_last_nxt   = 1'b0;
                end
                pend_v_nxt   = 1'b1;
                pend_nxt     = head;
                pend_idx_nxt = pos_r;
                cnt_nxt      = cnt_r + CNT_W'(1);
              end
            end
          end
        endcase

        if (!blocked) begin
          shift_en = 1'b1;
          pos_nxt  = last_pos ? '0 : pos_r + IDX_W'(1);
          if (last_pos) begin
            state_nxt = ST_RESP;
            if (op_r == OP_SAVE) begin
              if (hit_nxt || emp_v_nxt || del_v_nxt) begin
                res_found_nxt = 1'b1;
                res_idx_nxt   = hit_nxt ? hit_idx_nxt : (emp_v_nxt ? emp_idx_nxt : del_idx_nxt);
                state_nxt     = ST_WRITE;
              end else begin
                res_status_nxt = STAT_NO_SLOT;
              end
            end
          end
        end
      end

      ST_WRITE: begin
        shift_en = 1'b1;
        if (pos_r == res_idx_r) begin
          wb = '{st: SLOT_ACTIVE, key: key_r, kind: kind_r, nbytes: bytes_r};
        end
        pos_nxt = last_pos ? '0 : pos_r + IDX_W'(1);
        if (last_pos) begin
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_last_nxt   = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = '0;
          out_kind_nxt   = '0;
          out_bytes_nxt  = '0;
          if (op_r == OP_LIST) begin
            out_found_nxt = pend_v_r;
            out_idx_nxt   = pend_v_r ? idx4(pend_idx_r) : 4'd0;
            if (pend_v_r) begin
              out_key_nxt   = pend_r.key;
              out_kind_nxt  = pend_r.kind;
              out_bytes_nxt = pend_r.nbytes;
            end
          end else begin
            out_found_nxt = res_found_r;
            out_idx_nxt   = res_found_r ? idx4(res_idx_r) : 4'd0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      formatted_r <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      formatted_r <= formatted_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    kind_r       <= kind_nxt;
    bytes_r      <= bytes_nxt;
    pos_r        <= pos_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    emp_v_r      <= emp_v_nxt;
    emp_idx_r    <= emp_idx_nxt;
    del_v_r      <= del_v_nxt;
    del_idx_r    <= del_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_idx_r    <= res_idx_nxt;
    pend_r       <= pend_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_found_r  <= out_found_nxt;
    out_key_r    <= out_key_nxt;
    out_kind_r   <= out_kind_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_idx_r;
  assign out_found       = out_found_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_kind  = out_kind_r;
  assign out_entry_bytes = out_bytes_r;
  assign out_last        = out_last_r;

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start");

  // the write pass only runs with a chosen slot
  a_write_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> res_found_r)
    else $error("write pass without a chosen slot");

  // list never captures more than its limit
  a_list_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LIST))
    else $error("list count over limit");

  // mid-scan results come from list only and are never final
  a_scan_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && state_r == ST_SCAN) |-> (op_r == OP_LIST && !out_last_nxt))
    else $error("unexpected mid-scan result");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the template slot directory: save, delete, delete-all
// and list commands go in on the in_ channel, and a local copy of the slot
// directory predicts every result transaction that comes back on out_
// ----------------------------------------------------------------------------
module testbench;
  import tsd_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int SLOT_BYTES     = 4096;
  localparam int KEY_POOL       = 24;
  localparam int HOLD_CYCLES    = 300;
  // worst quiet stretch: long receiver hold-off plus a slow list, many times over
  localparam int WATCHDOG_LIMIT = 4000;
  // a save that writes takes two ring passes
  localparam int DRAIN_CYCLES   = 2 * NUM_SLOTS + 8;

  // one expected result transaction, fields at the port widths
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic        found;
    logic [15:0] key;
    logic [7:0]  kind;
    logic [12:0] nbytes;
    logic        last;
  } dir_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [15:0] in_template_key;
  logic [7:0]  in_template_kind;
  logic [12:0] in_template_bytes;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_index;
  logic        out_found;
  logic [15:0] out_entry_key;
  logic [7:0]  out_entry_kind;
  logic [12:0] out_entry_bytes;
  logic        out_last;

  // shadow copy of the directory
  slot_t       dir_slots [NUM_SLOTS];
  logic        dir_formatted;
  dir_result_t pending_results [$];

  logic [15:0] key_pool [KEY_POOL];

  // idling controls shared by the sender, the receiver and the tests
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  int mismatches;
  int quiet_cycles;
  int cmd_count [4];
  int results_checked;
  int entries_listed;
  int bad_len_count;
  int no_slot_count;

  template_slot_directory #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_template_key  (in_template_key),
    .in_template_kind (in_template_kind),
    .in_template_bytes(in_template_bytes),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_found        (out_found),
    .out_entry_key    (out_entry_key),
    .out_entry_kind   (out_entry_kind),
    .out_entry_bytes  (out_entry_bytes),
    .out_last         (out_last)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // directory model: applies one accepted command and queues its results
  // --------------------------------------------------------------------------
  function automatic void apply_directory_cmd(logic [1:0] op, logic [15:0] key,
                                              logic [7:0] kind, logic [12:0] nbytes);
    int          pick;
    int          first_empty;
    int          first_del;
    int          listed;
    logic        used;
    dir_result_t r;
    pick        = -1;
    first_empty = -1;
    first_del   = -1;
    listed      = 0;
    r           = '0;
    r.last      = 1'b1;
    cmd_count[op]++;
    case (op)
      OP_SAVE: begin
        if (nbytes == 0 || nbytes > SLOT_BYTES) begin
          // bad length leaves everything alone, the format flag too
          r.status = STAT_BAD_LEN;
          bad_len_count++;
        end else begin
          // formatting happens before the search, so even a full directory is formatted
          dir_formatted = 1'b1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            used = (dir_slots[i].st == SLOT_ACTIVE) || (dir_slots[i].st == SLOT_DELETED);
            if (used && dir_slots[i].key == key) begin
              pick = i;
              break;
            end
            // state code 3 counts as empty
            if (!used && first_empty < 0) first_empty = i;
            else if (dir_slots[i].st == SLOT_DELETED && first_del < 0) first_del = i;
          end
          if (pick < 0) pick = (first_empty >= 0) ? first_empty : first_del;
          if (pick < 0) begin
            r.status = STAT_NO_SLOT;
            no_slot_count++;
          end else begin
            dir_slots[pick].st     = SLOT_ACTIVE;
            dir_slots[pick].key    = key;
            dir_slots[pick].kind   = kind;
            dir_slots[pick].nbytes = nbytes;
            r.slot_index = 4'(pick);
            r.found      = 1'b1;
          end
        end
        pending_results.push_back(r);
      end
      OP_DEL_ID: begin
        if (dir_formatted) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (dir_slots[i].st == SLOT_ACTIVE && dir_slots[i].key == key) begin
              dir_slots[i].st = SLOT_DELETED;
              r.slot_index    = 4'(i);
              r.found         = 1'b1;
              break;
            end
          end
        end
        pending_results.push_back(r);
      end
      OP_DEL_ALL: begin
        if (dir_formatted) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (dir_slots[i].st == SLOT_ACTIVE) begin
              dir_slots[i].st = SLOT_DELETED;
              r.found         = 1'b1;
            end
          end
        end
        pending_results.push_back(r);
      end
      default: begin
        // list: one transaction per active slot with a sane length, in slot order, up to MAX_LIST
        if (dir_formatted) begin
          for (int i = 0; i < NUM_SLOTS && listed < MAX_LIST; i++) begin
            if (dir_slots[i].st == SLOT_ACTIVE && dir_slots[i].nbytes != 0 &&
                dir_slots[i].nbytes <= SLOT_BYTES) begin
              r.slot_index = 4'(i);
              r.found      = 1'b1;
              r.key        = dir_slots[i].key;
              r.kind       = dir_slots[i].kind;
              r.nbytes     = dir_slots[i].nbytes;
              r.last       = 1'b0;
              pending_results.push_back(r);
              listed++;
            end
          end
        end
        if (listed == 0) begin
          pending_results.push_back(r);
        end else begin
          // flag the final listed entry
          r      = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
          entries_listed += listed;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // sender: offers one command, optionally after an idle burst, and returns at
  // the edge where it was accepted
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [1:0] op, input logic [15:0] key,
                          input logic [7:0] kind, input logic [12:0] nbytes);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_template_key   <= key;
    in_template_kind  <= kind;
    in_template_bytes <= nbytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_directory_cmd(op, key, kind, nbytes);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : out_stall_gen
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off counted here so the sender keeps pushing into a full block
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every accepted result transaction against the oldest
  // prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    dir_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected (slot %0d)", out_slot_index);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",      32'(want.status),     32'(out_status));
        check_field("slot_index",  32'(want.slot_index), 32'(out_slot_index));
        check_field("found",       32'(want.found),      32'(out_found));
        check_field("entry_key",   32'(want.key),        32'(out_entry_key));
        check_field("entry_kind",  32'(want.kind),       32'(out_entry_kind));
        check_field("entry_bytes", 32'(want.nbytes),     32'(out_entry_bytes));
        check_field("last",        32'(want.last),       32'(out_last));
        results_checked++;
      end
    end
  end

  // watchdog: too long without any transaction on either channel means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // delete, delete-all and list before any save, and bad lengths that must
  // not format the directory
  task automatic test_unformatted();
    send_cmd(OP_LIST,    16'h0000, 8'h00, 13'd0);
    send_cmd(OP_DEL_ID,  16'hFFFF, 8'h00, 13'd0);
    send_cmd(OP_DEL_ALL, 16'h0000, 8'h00, 13'd0);
    send_cmd(OP_SAVE,    16'hFFFF, 8'hFF, 13'd0);
    send_cmd(OP_SAVE,    16'hFFFF, 8'hFF, 13'(SLOT_BYTES + 1));
    send_cmd(OP_SAVE,    16'h0000, 8'h00, 13'h1FFF);
    send_cmd(OP_LIST,    16'hFFFF, 8'hFF, 13'h1FFF);
  endtask

  // slot choice: same id reused, empty before tombstone, tombstone reused by id
  task automatic test_slot_reuse();
    send_cmd(OP_SAVE,   16'hFFFF, 8'hFF, 13'(SLOT_BYTES));
    send_cmd(OP_SAVE,   16'h0000, 8'h00, 13'd1);
    send_cmd(OP_SAVE,   16'hFFFF, 8'h5A, 13'd100);
    send_cmd(OP_DEL_ID, 16'hFFFF, 8'h00, 13'd0);
    send_cmd(OP_DEL_ID, 16'hFFFF, 8'h00, 13'd0);   // miss, already a tombstone
    send_cmd(OP_SAVE,   16'h1234, 8'hA5, 13'd2048);
    send_cmd(OP_SAVE,   16'hFFFF, 8'h3C, 13'(SLOT_BYTES - 1));
    send_cmd(OP_LIST,   16'h0000, 8'h00, 13'd0);
  endtask

  // every slot in use, save with no room, full-length list
  task automatic test_full_directory();
    send_cmd(OP_DEL_ALL, 16'h0000, 8'h00, 13'd0);
    send_cmd(OP_LIST,    16'h0000, 8'h00, 13'd0);  // formatted but nothing active
    for (int i = 0; i < NUM_SLOTS; i++)
      send_cmd(OP_SAVE, 16'h0100 + 16'(i), 8'($urandom), 13'($urandom_range(1, SLOT_BYTES)));
    send_cmd(OP_SAVE,   16'hBEEF, 8'h11, 13'd64);   // no free slot
    send_cmd(OP_LIST,   16'h0000, 8'h00, 13'd0);
    send_cmd(OP_SAVE,   16'h0105, 8'h22, 13'd77);   // same id still fits when full
    send_cmd(OP_DEL_ID, 16'h0103, 8'h00, 13'd0);
    send_cmd(OP_SAVE,   16'hBEEF, 8'h33, 13'd99);   // lands in the tombstone
  endtask

  // random commands over a small or a wide key pool so saves and deletes hit
  task automatic test_random(input int count, input bit idle_ok);
    logic [1:0]  op;
    logic [15:0] key;
    logic [12:0] nbytes;
    int          pool_n;
    int          roll;
    pool_n = KEY_POOL;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        pool_n     = ($urandom_range(0, 1) != 0) ? 6 : KEY_POOL;
        tx_idle_on = idle_ok && ($urandom_range(0, 2) != 0);
        rx_idle_on = idle_ok && ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 45)      op = OP_SAVE;
      else if (roll < 70) op = OP_DEL_ID;
      else if (roll < 74) op = OP_DEL_ALL;
      else                op = OP_LIST;
      key  = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                         : key_pool[$urandom_range(0, pool_n - 1)];
      roll = $urandom_range(0, 19);
      if (roll == 0)     nbytes = 13'd0;
      else if (roll == 1) nbytes = 13'(SLOT_BYTES);
      else if (roll < 4)  nbytes = 13'($urandom_range(SLOT_BYTES + 1, 8191));
      else                nbytes = 13'($urandom_range(1, SLOT_BYTES));
      send_cmd(op, key, 8'($urandom), nbytes);
    end
  endtask

  // receiver holds off for a long stretch while lists keep coming, so the
  // block backs up and stalls its input
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < 4; i++)
      send_cmd(OP_SAVE, key_pool[i], 8'($urandom), 13'($urandom_range(1, SLOT_BYTES)));
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_cmd(OP_LIST, 16'($urandom), 8'($urandom), 13'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_opcode         = OP_SAVE;
    in_template_key   = '0;
    in_template_kind  = '0;
    in_template_bytes = '0;
    tx_idle_on        = 1'b0;
    rx_idle_on        = 1'b0;
    hold_req          = 1'b0;
    dir_formatted     = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) dir_slots[i] = '0;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with idling on both sides to shift gaps across phases
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_unformatted();
    test_slot_reuse();
    test_full_directory();
    test_random(200, 1'b1);
    test_backpressure();
    // closing stretch at full rate on both sides
    test_random(40, 1'b0);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("commands: %0d save, %0d delete, %0d delete-all, %0d list",
             cmd_count[OP_SAVE], cmd_count[OP_DEL_ID], cmd_count[OP_DEL_ALL],
             cmd_count[OP_LIST]);
    $display("results checked: %0d (%0d listed entries, %0d bad lengths, %0d no-slot saves)",
             results_checked, entries_listed, bad_len_count, no_slot_count);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_cell.sv
hw/rtl/tsd_ctrl.sv
hw/rtl/template_slot_directory.sv
tb/testbench.sv
